// ----- design/lwf_pkg.sv -----
`default_nettype none

package lwf_pkg;

	typedef logic [1:0] kind_t;
	typedef logic [1:0] heading_t;
	typedef logic [1:0] action_t;

	localparam int KIND_W = 2;

	localparam kind_t KIND_WALL = 2'd0;
	localparam kind_t KIND_OPEN = 2'd1;
	localparam kind_t KIND_EXIT = 2'd2;

	localparam heading_t HEAD_UP    = 2'd0;
	localparam heading_t HEAD_RIGHT = 2'd1;
	localparam heading_t HEAD_DOWN  = 2'd2;
	localparam heading_t HEAD_LEFT  = 2'd3;

	localparam action_t ACT_WRITE = 2'd0;
	localparam action_t ACT_PLACE = 2'd1;
	localparam action_t ACT_STEP  = 2'd2;

	function automatic logic passable(input kind_t kind);
		return (kind == KIND_OPEN) || (kind == KIND_EXIT);
	endfunction

endpackage

`default_nettype wire

// ----- design/left_wall_follower_step_core.sv -----
`default_nettype none

// Left-hand wall follower over a GRID_SIDE x GRID_SIDE maze held in one
// single-port cell store (synchronous read).
// Input channel (in_valid / in_stall): one transfer carries action, row, col,
// cell_kind and start_heading. Action 0 writes a cell, 1 places the walker,
// 2 takes one step, 3 only reports. Out-of-grid writes and placements are
// dropped. Output channel (out_valid / out_stall): exactly one transfer per
// item with the walker's row, column, heading, moved flag and exit flag.
// Sequencing: a write, report or dropped placement goes from execute to
// finish; a placement passes a place state that reads the new cell for the
// exit flag; a step works in the step state, then finishes. A step reads the
// left, forward and right neighbours back to back through the one store
// port, a read each cycle, and stops at the first open or exit cell; that
// port sets the step time. The result then sits in an output register, so
// the next item is taken while the receiver still stalls; a second result
// waits in the sequencer until the register frees.
// Reset: position (1,1), heading right, then a clearing pass writes wall to
// every cell, during which in_stall stays high.
module left_wall_follower_step_core #(
	parameter int GRID_SIDE = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [1:0] action,
	input  wire logic [5:0] row,
	input  wire logic [5:0] col,
	input  wire logic [1:0] cell_kind,
	input  wire logic [1:0] start_heading,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [5:0]      walker_row,
	output logic [5:0]      walker_col,
	output logic [1:0]      walker_heading,
	output logic            moved,
	output logic            on_exit
);

	localparam int RW    = $clog2(GRID_SIDE);
	localparam int PW    = (RW > 6) ? RW : 6;
	localparam int DEPTH = GRID_SIDE * GRID_SIDE;
	localparam int AW    = $clog2(DEPTH);

	// sequencer states
	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_EXEC  = 3'd2;
	localparam logic [2:0] ST_STEP  = 3'd3;
	localparam logic [2:0] ST_PLACE = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;

	logic [2:0]             state_q;
	logic [AW-1:0]          clr_q;

	// walker state
	logic [PW-1:0]          pos_row_q;
	logic [PW-1:0]          pos_col_q;
	lwf_pkg::heading_t      heading_q;
	logic                   exit_q;
	logic                   moved_q;

	// item being worked on
	lwf_pkg::action_t       act_q;
	logic [5:0]             row_q;
	logic [5:0]             col_q;
	lwf_pkg::kind_t         kind_q;
	lwf_pkg::heading_t      sh_q;

	// neighbour read pipeline
	logic [1:0]             iss_q;
	logic                   chk_vld_s1;
	logic                   chk_last_s1;
	logic                   chk_blk_s1;
	lwf_pkg::heading_t      chk_dir_s1;
	logic [PW-1:0]          chk_row_s1;
	logic [PW-1:0]          chk_col_s1;

	// output register
	logic                   out_valid_q;
	logic [5:0]             out_row_q;
	logic [5:0]             out_col_q;
	lwf_pkg::heading_t      out_heading_q;
	logic                   out_moved_q;
	logic                   out_exit_q;

	// store port
	logic                   ram_en;
	logic                   ram_we;
	logic [AW-1:0]          ram_addr;
	lwf_pkg::kind_t         ram_wdata;
	lwf_pkg::kind_t         ram_rdata;

	lwf_pkg::heading_t      cand_dir;
	logic [PW-1:0]          nb_row;
	logic [PW-1:0]          nb_col;
	logic [AW-1:0]          nb_addr;
	logic                   nb_blocked;

	logic                   accept;
	logic                   out_free;
	logic                   clr_last;
	logic                   item_in_grid;
	logic [AW-1:0]          item_addr;
	logic                   step_hit;
	logic                   step_give_up;
	logic                   step_issue;

	assign accept   = (state_q == ST_IDLE) && in_valid;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign clr_last = (clr_q == AW'(DEPTH - 1));

	assign item_in_grid = (int'(row_q) < GRID_SIDE) && (int'(col_q) < GRID_SIDE);
	assign item_addr    = AW'(row_q) * AW'(GRID_SIDE) + AW'(col_q);

	// candidates in order: left, forward, right
	assign cand_dir = heading_q + lwf_pkg::heading_t'(iss_q) + 2'd3;

	lwf_nbr #(
		.GRID_SIDE(GRID_SIDE)
	) u_nbr (
		.pos_row   (pos_row_q),
		.pos_col   (pos_col_q),
		.dir       (cand_dir),
		.nb_row    (nb_row),
		.nb_col    (nb_col),
		.nb_addr   (nb_addr),
		.nb_blocked(nb_blocked)
	);

	// first passable candidate wins; after the right-hand one, turn around
	assign step_hit     = (state_q == ST_STEP) && chk_vld_s1 && !chk_blk_s1
		&& lwf_pkg::passable(ram_rdata);
	assign step_give_up = (state_q == ST_STEP) && chk_vld_s1 && chk_last_s1 && !step_hit;
	assign step_issue   = (state_q == ST_STEP) && !step_hit && !step_give_up
		&& (iss_q != 2'd3);

	always_comb begin
		ram_en    = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = item_addr;
		ram_wdata = kind_q;
		unique case (state_q)
			ST_CLEAR: begin
				ram_en    = 1'b1;
				ram_we    = 1'b1;
				ram_addr  = clr_q;
				ram_wdata = lwf_pkg::KIND_WALL;
			end
			ST_EXEC: begin
				if (item_in_grid && (act_q == lwf_pkg::ACT_WRITE)) begin
					ram_en = 1'b1;
					ram_we = 1'b1;
				end else if (item_in_grid && (act_q == lwf_pkg::ACT_PLACE)) begin
					ram_en = 1'b1;
				end
			end
			ST_STEP: begin
				// skip the read where the edge already blocks the move
				ram_en   = step_issue && !nb_blocked;
				ram_addr = nb_addr;
			end
			default: begin
				ram_en = 1'b0;
			end
		endcase
	end

	lwf_ram #(
		.WIDTH(lwf_pkg::KIND_W),
		.DEPTH(DEPTH)
	) u_cells (
		.clk  (clk),
		.en   (ram_en),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// control and walker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			pos_row_q   <= PW'(1);
			pos_col_q   <= PW'(1);
			heading_q   <= lwf_pkg::HEAD_RIGHT;
			exit_q      <= 1'b0;
			moved_q     <= 1'b0;
			iss_q       <= 2'd0;
			chk_vld_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						moved_q    <= 1'b0;
						iss_q      <= 2'd0;
						chk_vld_s1 <= 1'b0;
						state_q    <= (action == lwf_pkg::ACT_STEP) ? ST_STEP : ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_FIN;
					case (act_q)
						lwf_pkg::ACT_WRITE: begin
							// a write under the walker changes its exit flag
							if (item_in_grid && (PW'(row_q) == pos_row_q)
								&& (PW'(col_q) == pos_col_q)) begin
								exit_q <= (kind_q == lwf_pkg::KIND_EXIT);
							end
						end
						lwf_pkg::ACT_PLACE: begin
							if (item_in_grid) begin
								pos_row_q <= PW'(row_q);
								pos_col_q <= PW'(col_q);
								heading_q <= sh_q;
								state_q   <= ST_PLACE;
							end
						end
						default: begin
							state_q <= ST_FIN;
						end
					endcase
				end
				ST_STEP: begin
					if (step_hit) begin
						pos_row_q  <= chk_row_s1;
						pos_col_q  <= chk_col_s1;
						heading_q  <= chk_dir_s1;
						exit_q     <= (ram_rdata == lwf_pkg::KIND_EXIT);
						moved_q    <= 1'b1;
						chk_vld_s1 <= 1'b0;
						state_q    <= ST_FIN;
					end else if (step_give_up) begin
						heading_q  <= heading_q + 2'd2;
						chk_vld_s1 <= 1'b0;
						state_q    <= ST_FIN;
					end else if (step_issue) begin
						chk_vld_s1 <= 1'b1;
						iss_q      <= iss_q + 2'd1;
					end
				end
				ST_PLACE: begin
					exit_q  <= (ram_rdata == lwf_pkg::KIND_EXIT);
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// hold the result while stalled, drop it once taken
			if ((state_q == ST_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q  <= action;
			row_q  <= row;
			col_q  <= col;
			kind_q <= cell_kind;
			sh_q   <= start_heading;
		end
	end

	// candidate travelling with its read
	always_ff @(posedge clk) begin
		if (step_issue) begin
			chk_dir_s1  <= cand_dir;
			chk_row_s1  <= nb_row;
			chk_col_s1  <= nb_col;
			chk_blk_s1  <= nb_blocked;
			chk_last_s1 <= (iss_q == 2'd2);
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if ((state_q == ST_FIN) && out_free) begin
			out_row_q     <= pos_row_q[5:0];
			out_col_q     <= pos_col_q[5:0];
			out_heading_q <= heading_q;
			out_moved_q   <= moved_q;
			out_exit_q    <= exit_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign walker_row     = out_row_q;
	assign walker_col     = out_col_q;
	assign walker_heading = out_heading_q;
	assign moved          = out_moved_q;
	assign on_exit        = out_exit_q;

	a_pos_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(pos_row_q) < GRID_SIDE) && (int'(pos_col_q) < GRID_SIDE))
		else $error("walker position left the grid");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_FIN))
		else $error("result raised outside the finish state");

	a_last_candidate_ends: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_STEP) && chk_vld_s1 && chk_last_s1) |=> (state_q == ST_FIN))
		else $error("step did not end after the right-hand candidate");

	a_no_write_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_STEP) || (state_q == ST_PLACE)) |-> !(ram_en && ram_we))
		else $error("cell store written during a step or placement");

	a_moved_only_on_step: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (action != lwf_pkg::ACT_STEP)) |=> ##1 !moved_q)
		else $error("moved flag set for an item that is not a step");

endmodule

`default_nettype wire

// ----- design/lwf_ram.sv -----
`default_nettype none

module lwf_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 4096,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic             we,
	input  wire logic [AW-1:0]    addr,
	input  wire logic [WIDTH-1:0] wdata,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata_q <= mem[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- design/lwf_nbr.sv -----
`default_nettype none

// Neighbour cell of the walker in one direction: coordinates, store address
// and whether the grid edge blocks it.
module lwf_nbr #(
	parameter int GRID_SIDE = 64,
	localparam int RW = $clog2(GRID_SIDE),
	localparam int PW = (RW > 6) ? RW : 6,
	localparam int AW = $clog2(GRID_SIDE * GRID_SIDE)
) (
	input  wire logic [PW-1:0]          pos_row,
	input  wire logic [PW-1:0]          pos_col,
	input  wire lwf_pkg::heading_t      dir,
	output logic      [PW-1:0]          nb_row,
	output logic      [PW-1:0]          nb_col,
	output logic      [AW-1:0]          nb_addr,
	output logic                        nb_blocked
);

	localparam logic [PW-1:0] EDGE = PW'(GRID_SIDE - 1);

	always_comb begin
		nb_row     = pos_row;
		nb_col     = pos_col;
		nb_blocked = 1'b0;
		unique case (dir)
			lwf_pkg::HEAD_UP: begin
				nb_blocked = (pos_row == '0);
				nb_row     = pos_row - PW'(1);
			end
			lwf_pkg::HEAD_RIGHT: begin
				nb_blocked = (pos_col == EDGE);
				nb_col     = pos_col + PW'(1);
			end
			lwf_pkg::HEAD_DOWN: begin
				nb_blocked = (pos_row == EDGE);
				nb_row     = pos_row + PW'(1);
			end
			lwf_pkg::HEAD_LEFT: begin
				nb_blocked = (pos_col == '0);
				nb_col     = pos_col - PW'(1);
			end
			default: begin
				nb_blocked = 1'b1;
			end
		endcase
	end

	// only meaningful when not blocked
	assign nb_addr = AW'(nb_row) * AW'(GRID_SIDE) + AW'(nb_col);

endmodule

`default_nettype wire
